FILE: src/nls_pkg.sv
// ---------------------------------------------------------------------------
// nls_pkg - shared definitions for the natural log series unit
// Types, constants and reciprocal table used by the controller and the
// datapath of the atanh-series logarithm.
// ---------------------------------------------------------------------------
package nls_pkg;

  // Default configuration of the series and of the operand format.
  localparam int SERIES_LAST_ODD_DEF = 19;
  localparam int INPUT_FRAC_BITS_DEF = 16;

  // Magnitude of y = (m-1)/(m+1) in Q30 stays below 0.1716, so 28 bits.
  localparam int Y_W = 28;
  // Quotient bits produced by the restoring divider, one per cycle.
  localparam int DIV_STEPS = Y_W;
  // Normalising search: shifts of 16, 8, 4, 2 and 1.
  localparam int NORM_STEPS = 5;
  localparam int CNT_W = 5;
  // Term index k selects n = 2k+1, for n up to 31.
  localparam int IDX_W = 4;

  // Twice the Q30 square root of two, compared with a mantissa whose top
  // bit is bit 31.
  localparam logic [31:0] SQRT2X2 = 32'd3037000500;
  localparam logic signed [31:0] LN2_Q24 = 32'sd11629080;
  localparam logic [31:0] MOST_NEG_Q24 = 32'h8000_0000;

  // Reciprocals ceil(2^33 / n) for odd n; the entry for n = 1 is bypassed.
  localparam int RECIP_SHIFT = 33;
  localparam logic [31:0] RECIP [16] = '{
    32'd0,          32'd2863311531, 32'd1717986919, 32'd1227133514,
    32'd954437177,  32'd780903145,  32'd660764200,  32'd572662307,
    32'd505290271,  32'd452101821,  32'd409044505,  32'd373475418,
    32'd343597384,  32'd318145726,  32'd296204642,  32'd277094665
  };

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_PREP,
    ST_DIV,
    ST_SQUARE,
    ST_RECIP,
    ST_TERM,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             norm;
    logic             prep;
    logic             div;
    logic             square;
    logic             recip;
    logic             term;
    logic             finish;
    logic [CNT_W-1:0] cnt;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero;
  } status_t;

endpackage

FILE: src/nls_ctrl.sv
// ---------------------------------------------------------------------------
// nls_ctrl - sequencer of the natural log series unit
// Steps one item through normalisation, division, squaring and the series
// terms, and issues the commands that drive the datapath.
// ---------------------------------------------------------------------------
module nls_ctrl
  import nls_pkg::*;
#(
  parameter int SERIES_LAST_ODD = SERIES_LAST_ODD_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t st,
  output logic    busy,
  output cmd_t    cmd
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'((SERIES_LAST_ODD - 1) / 2);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] idx, idx_next;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      idx   <= idx_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    idx_next   = idx;
    cmd        = '0;
    cmd.cnt    = cnt;
    cmd.idx    = idx;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cnt_next   = CNT_W'(NORM_STEPS - 1);
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        if (st.zero) begin
          state_next = ST_FINISH;
        end else begin
          cmd.norm = 1'b1;
          if (cnt == '0) begin
            state_next = ST_PREP;
          end else begin
            cnt_next = cnt - 1'b1;
          end
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = CNT_W'(DIV_STEPS - 1);
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (cnt == '0) begin
          state_next = ST_SQUARE;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        idx_next   = '0;
        state_next = ST_RECIP;
      end
      ST_RECIP: begin
        cmd.recip  = 1'b1;
        state_next = ST_TERM;
      end
      ST_TERM: begin
        cmd.term = 1'b1;
        if (idx == LAST_IDX) begin
          state_next = ST_FINISH;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_RECIP;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/nls_datapath.sv
// ---------------------------------------------------------------------------
// nls_datapath - arithmetic of the natural log series unit
// Normalising shifter, restoring divider, series multiplier and the final
// scaling and exponent correction, all under controller command.
// ---------------------------------------------------------------------------
module nls_datapath
  import nls_pkg::*;
#(
  parameter int INPUT_FRAC_BITS = INPUT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] value_raw,
  input  cmd_t        cmd,
  output status_t     st,
  output logic        done,
  output logic [31:0] log_value,
  output logic        zero_input
);

  logic [31:0]        norm;
  logic [4:0]         lz;
  logic               zero;
  logic               neg;
  logic signed [6:0]  expo;
  logic [60:0]        rem;
  logic [59:0]        dsr;
  logic [Y_W-1:0]     quo;
  logic [25:0]        y2;
  logic [Y_W-1:0]     term;
  logic [59:0]        preg;
  logic [29:0]        sum;

  assign st.zero = zero;

  // Mantissa compared with the square root of two picks the exponent.
  logic        s_hi;
  logic [31:0] num_mag;
  logic [32:0] den;
  logic [5:0]  s_val;
  logic [6:0]  expo_next;

  always_comb begin
    s_hi      = (norm > SQRT2X2);
    num_mag   = s_hi ? 32'(33'h1_0000_0000 - {1'b0, norm}) : (norm - 32'h8000_0000);
    den       = s_hi ? {1'b1, norm} : ({1'b0, norm} + 33'h0_8000_0000);
    s_val     = 6'd31 - {1'b0, lz} + {5'd0, s_hi};
    expo_next = 7'({1'b0, s_val}) - 7'(INPUT_FRAC_BITS);
  end

  // Multipliers of the squaring and series steps.
  logic [55:0] sq_prod;
  logic [59:0] rc_prod;
  logic [53:0] tm_prod;

  assign sq_prod = quo * quo;
  assign rc_prod = term * RECIP[cmd.idx];
  assign tm_prod = term * y2;

  // Final scaling: floor shift of twice the sum, plus the exponent term.
  logic [30:0]        mag2;
  logic [30:0]        mag2_rnd;
  logic [31:0]        fs_u;
  logic [31:0]        fs;
  logic signed [31:0] expo_ext;
  logic signed [31:0] ln2_part;
  logic [31:0]        res;

  always_comb begin
    mag2     = {sum, 1'b0};
    mag2_rnd = mag2 + 31'd63;
    fs_u     = neg ? {7'd0, mag2_rnd[30:6]} : {7'd0, mag2[30:6]};
    fs       = neg ? (32'd0 - fs_u) : fs_u;
    expo_ext = 32'(expo);
    ln2_part = expo_ext * LN2_Q24;
    res      = fs + ln2_part;
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      norm <= value_raw;
      lz   <= '0;
      zero <= (value_raw == 32'd0);
    end

    // One step of the binary search for the leading one.
    if (cmd.norm) begin
      case (cmd.cnt[2:0])
        3'd4: begin
          if (norm[31:16] == '0) begin
            norm <= norm << 16;
            lz   <= lz + 5'd16;
          end
        end
        3'd3: begin
          if (norm[31:24] == '0) begin
            norm <= norm << 8;
            lz   <= lz + 5'd8;
          end
        end
        3'd2: begin
          if (norm[31:28] == '0) begin
            norm <= norm << 4;
            lz   <= lz + 5'd4;
          end
        end
        3'd1: begin
          if (norm[31:30] == '0) begin
            norm <= norm << 2;
            lz   <= lz + 5'd2;
          end
        end
        3'd0: begin
          if (!norm[31]) begin
            norm <= norm << 1;
            lz   <= lz + 5'd1;
          end
        end
        default: begin
        end
      endcase
    end

    // Set up the divider for |m-1| * 2^30 / (m+1).
    if (cmd.prep) begin
      neg  <= s_hi;
      expo <= expo_next;
      rem  <= {num_mag[30:0], 30'd0};
      dsr  <= {den, 27'd0};
      quo  <= '0;
      sum  <= '0;
    end

    // Restoring division, one quotient bit per cycle.
    if (cmd.div) begin
      if (rem >= {1'b0, dsr}) begin
        rem <= rem - {1'b0, dsr};
        quo <= {quo[Y_W-2:0], 1'b1};
      end else begin
        quo <= {quo[Y_W-2:0], 1'b0};
      end
      dsr <= dsr >> 1;
    end

    // y squared in Q30; the first term is y itself.
    if (cmd.square) begin
      y2   <= sq_prod[55:30];
      term <= quo;
    end

    // Term divided by n through its reciprocal.
    if (cmd.recip) begin
      preg <= rc_prod;
    end

    // Accumulate the quotient and advance to the next odd power.
    if (cmd.term) begin
      if (cmd.idx == '0) begin
        sum <= sum + 30'(term);
      end else begin
        sum <= sum + 30'(preg[59:RECIP_SHIFT]);
      end
      term <= Y_W'(tm_prod[53:30]);
    end

    // Result registers.
    if (cmd.finish) begin
      if (zero) begin
        log_value  <= MOST_NEG_Q24;
        zero_input <= 1'b1;
      end else begin
        log_value  <= res;
        zero_input <= 1'b0;
      end
    end
  end

endmodule

FILE: src/natural_log_series_unit.sv
// ---------------------------------------------------------------------------
// natural_log_series_unit - natural logarithm by the atanh series
// Unsigned fixed-point operand in, signed Q7.24 logarithm out.
//
//   Channel  Signals                      Direction  Meaning
//   input    start, busy, value_raw       in / out   operand item
//   result   done, log_value, zero_input  out        logarithm item
//
// An item is taken at a rising edge with start high and busy low. Busy then
// stays high through five normalising steps, a set-up state, the restoring
// divider (a 28-bit quotient), a squaring state, a reciprocal multiply and a
// term step for each series term up to SERIES_LAST_ODD, and a final state.
// A zero operand leaves normalising at once for the final state.
// Done is high for one cycle with the result; the receiver cannot stall it.
// Reset clears the sequencer and the strobe; no item is in flight after it.
// ---------------------------------------------------------------------------
module natural_log_series_unit
  import nls_pkg::*;
#(
  parameter int SERIES_LAST_ODD = SERIES_LAST_ODD_DEF,
  parameter int INPUT_FRAC_BITS = INPUT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value_raw,
  output logic        done,
  output logic [31:0] log_value,
  output logic        zero_input
);

  cmd_t    cmd;
  status_t st;

  // Sequencer.
  nls_ctrl #(
    .SERIES_LAST_ODD(SERIES_LAST_ODD)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Arithmetic.
  nls_datapath #(
    .INPUT_FRAC_BITS(INPUT_FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .value_raw  (value_raw),
    .cmd        (cmd),
    .st         (st),
    .done       (done),
    .log_value  (log_value),
    .zero_input (zero_input)
  );

endmodule
